/* sv/ncap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncap_pkg
// Shared types and the control program of the nearest capacity allocator.
// ----------------------------------------------------------------------------
package ncap_pkg;

	localparam int COORD_W = 14;
	localparam int CAP_W   = 16;
	localparam int DIST_W  = 15;
	localparam int STEP_W  = 3;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_WAIT     = 3'd0;
	localparam step_t STEP_DISPATCH = 3'd1;
	localparam step_t STEP_SCAN     = 3'd2;
	localparam step_t STEP_DRAIN0   = 3'd3;
	localparam step_t STEP_DRAIN1   = 3'd4;
	localparam step_t STEP_COMMIT   = 3'd5;
	localparam step_t STEP_LOAD     = 3'd6;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_NO_TXN,
		COND_IS_LOAD,
		COND_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  clr_scan;
		logic  issue;
		logic  load_wr;
		logic  commit;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic in_txn;
		logic is_load;
		logic more;
		logic out_busy;
	} seq_status_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CAP_W-1:0]   cap;
		logic [CAP_W-1:0]   cnt;
	} site_entry_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '{in_ready: 1'b0, clr_scan: 1'b0, issue: 1'b0, load_wr: 1'b0,
			commit: 1'b0, cond: COND_ALWAYS, target: STEP_WAIT};
		unique case (step)
			STEP_WAIT: begin
				w.in_ready = 1'b1;
				w.cond     = COND_NO_TXN;
				w.target   = STEP_WAIT;
			end
			STEP_DISPATCH: begin
				w.clr_scan = 1'b1;
				w.cond     = COND_IS_LOAD;
				w.target   = STEP_LOAD;
			end
			STEP_SCAN: begin
				w.issue  = 1'b1;
				w.cond   = COND_MORE;
				w.target = STEP_SCAN;
			end
			STEP_DRAIN0: begin
				w.cond = COND_NEXT;
			end
			STEP_DRAIN1: begin
				w.cond   = COND_OUT_BUSY;
				w.target = STEP_DRAIN1;
			end
			STEP_COMMIT: begin
				w.commit = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
			STEP_LOAD: begin
				w.load_wr = 1'b1;
				w.cond    = COND_ALWAYS;
				w.target  = STEP_WAIT;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

/* sv/ncap_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncap_sequencer
// Step counter over the control program, with conditional jumps.
// ----------------------------------------------------------------------------
module ncap_sequencer
	import ncap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output ucode_t      ctl
);

	step_t step_q;
	step_t step_d;
	logic  jump;

	assign ctl = ucode_rom(step_q);

	always_comb begin
		unique case (ctl.cond)
			COND_NEXT:     jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_NO_TXN:   jump = !status.in_txn;
			COND_IS_LOAD:  jump = status.is_load;
			COND_MORE:     jump = status.more;
			COND_OUT_BUSY: jump = status.out_busy;
			default:       jump = 1'b1;
		endcase
	end

	always_comb begin
		step_d = jump ? ctl.target : step_t'(step_q + step_t'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

/* sv/ncap_site_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncap_site_mem
// Site table with one write port, one registered read port and valid bits.
// ----------------------------------------------------------------------------
module ncap_site_mem
	import ncap_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  site_entry_t   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output site_entry_t   rd_data
);

	site_entry_t      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	site_entry_t      rd_raw_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// An entry never written reads with zero capacity and zero count.
	always_comb begin
		rd_data   = rd_raw_q;
		if (!rd_valid_q) begin
			rd_data.cap = '0;
			rd_data.cnt = '0;
		end
	end

endmodule

/* sv/nearest_capacity_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_capacity_allocator
// Capacity-limited nearest-site allocator driven by a small control program.
// ----------------------------------------------------------------------------
// Input transactions arrive on s_axis. With tuser low a transaction loads one
// site (index, x, y, capacity) and clears its assignment count; it produces
// no output. With tuser high it is a request: the sites below sites_in_use
// are read from the site table one per cycle, and the one with free capacity
// and least Manhattan distance wins, ties going to smaller x, then smaller
// y, then lower index. The number of sites searched is sites_in_use capped
// at MAX_SITES. One output transaction per request appears on m_axis; tuser
// is the found flag. The result sits in an output register, so the next
// input is taken while it waits; a stalled receiver holds a later request
// just before its commit step. sites_in_use is written through cfg_wr_en;
// the user must write it only while idle, as the block does not enforce
// this. Reset clears all capacities, counts, sites_in_use and the output
// valid flag.
// ----------------------------------------------------------------------------
module nearest_capacity_allocator
	import ncap_pkg::*;
#(
	parameter int MAX_SITES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,    // sites_in_use
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // site_index, point_x, point_y, site_capacity
	input  logic        s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // chosen_site, distance, site_count, zero pad
	output logic        m_axis_tuser    // found
);

	localparam int IW  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int CW  = $clog2(MAX_SITES + 1);
	localparam int LW  = (CW > 5) ? CW : 5;

	ucode_t      ctl;
	seq_status_t status;

	logic [4:0]         sites_q;
	logic [LW-1:0]      limit;
	logic [LW-1:0]      scan_q;
	logic [LW:0]        scan_next;

	logic               func_q;
	logic [3:0]         ld_idx_q;
	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [CAP_W-1:0]   cap_q;
	logic [LW-1:0]      ld_idx_w;
	logic               ld_ok;

	logic               rd_en;
	site_entry_t        rd_data;
	logic               pend_s1;
	logic [IW-1:0]      idx_s1;

	logic               cand_s2;
	logic [DIST_W-1:0]  d_s2;
	site_entry_t        ent_s2;
	logic [IW-1:0]      idx_s2;
	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;
	logic               take;

	logic               have_q;
	logic [DIST_W-1:0]  best_d_q;
	site_entry_t        best_q;
	logic [IW-1:0]      best_idx_q;
	logic [LW-1:0]      best_idx_w;

	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	site_entry_t        wr_data;

	logic               out_valid_q;
	logic               out_found_q;
	logic [3:0]         out_site_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic [CAP_W-1:0]   out_cnt_q;

	// Control.
	ncap_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	assign s_axis_tready = ctl.in_ready;
	assign scan_next     = {1'b0, scan_q} + (LW + 1)'(1);

	always_comb begin
		if (LW'(sites_q) > LW'(MAX_SITES)) begin
			limit = LW'(MAX_SITES);
		end else begin
			limit = LW'(sites_q);
		end
	end

	always_comb begin
		status.in_txn   = s_axis_tvalid & ctl.in_ready;
		status.is_load  = (func_q == FUNC_LOAD);
		status.more     = scan_next < {1'b0, limit};
		status.out_busy = out_valid_q & !m_axis_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sites_q <= '0;
		end else if (cfg_wr_en) begin
			sites_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (status.in_txn) begin
			func_q   <= s_axis_tuser;
			ld_idx_q <= s_axis_tdata[3:0];
			px_q     <= s_axis_tdata[17:4];
			py_q     <= s_axis_tdata[31:18];
			cap_q    <= s_axis_tdata[47:32];
		end
	end

	// Scan counter and site table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctl.clr_scan) begin
			scan_q <= '0;
		end else if (ctl.issue) begin
			scan_q <= scan_next[LW-1:0];
		end
	end

	assign rd_en    = ctl.issue & (scan_q < limit);
	assign ld_idx_w = LW'(ld_idx_q);
	assign ld_ok    = ld_idx_w < LW'(MAX_SITES);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ld_idx_w[IW-1:0];
		wr_data = '{x: px_q, y: py_q, cap: cap_q, cnt: '0};
		if (ctl.load_wr) begin
			wr_en = ld_ok;
		end else if (ctl.commit) begin
			wr_en       = have_q;
			wr_addr     = best_idx_q;
			wr_data     = best_q;
			wr_data.cap = best_q.cap - CAP_W'(1);
			wr_data.cnt = best_q.cnt + CAP_W'(1);
		end
	end

	ncap_site_mem #(
		.DEPTH (MAX_SITES),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_q[IW-1:0]),
		.rd_data (rd_data)
	);

	// Distance stage.
	always_comb begin
		dx = (px_q > rd_data.x) ? (px_q - rd_data.x) : (rd_data.x - px_q);
		dy = (py_q > rd_data.y) ? (py_q - rd_data.y) : (rd_data.y - py_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			cand_s2 <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			cand_s2 <= pend_s1 & (rd_data.cap != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= scan_q[IW-1:0];
		end
		d_s2   <= {1'b0, dx} + {1'b0, dy};
		ent_s2 <= rd_data;
		idx_s2 <= idx_s1;
	end

	// Best-candidate stage.
	always_comb begin
		take = cand_s2 & (!have_q || (d_s2 < best_d_q) ||
			((d_s2 == best_d_q) && ((ent_s2.x < best_q.x) ||
			((ent_s2.x == best_q.x) && (ent_s2.y < best_q.y)))));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clr_scan) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_d_q   <= d_s2;
			best_q     <= ent_s2;
			best_idx_q <= idx_s2;
		end
	end

	assign best_idx_w = LW'(best_idx_q);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_found_q <= have_q;
			out_site_q  <= have_q ? best_idx_w[3:0] : 4'd0;
			out_dist_q  <= have_q ? best_d_q : '0;
			out_cnt_q   <= have_q ? (best_q.cnt + CAP_W'(1)) : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {5'd0, out_cnt_q, out_dist_q, out_site_q};

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest capacity allocator.
// ----------------------------------------------------------------------------
// Site loads and allocation requests are streamed in with random gaps, and
// the result stream is stalled at random. A scoreboard keeps its own copy of
// the site table and predicts every result, which is then compared field by
// field. A short directed sequence covers the coordinate extremes, ties on
// distance, x and y, exhausted and zero capacity, and an out-of-range site
// count. Random phases at several site counts follow. Tight coordinate grids
// force ties, and small capacities force exhaustion.
// ----------------------------------------------------------------------------
module testbench;
	import ncap_pkg::*;

	localparam int SITE_SLOTS  = 16;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		bit                found;
		bit [3:0]          site;
		bit [DIST_W-1:0]   distance;
		bit [CAP_W-1:0]    count;
	} alloc_result_t;

	class allocator_scoreboard;
		bit [COORD_W-1:0] x_tab [SITE_SLOTS];
		bit [COORD_W-1:0] y_tab [SITE_SLOTS];
		bit [CAP_W-1:0]   cap_tab [SITE_SLOTS];
		bit [CAP_W-1:0]   cnt_tab [SITE_SLOTS];
		bit [4:0]         sites_in_use;
		alloc_result_t    expected_q [$];
		int mismatches;
		int loads;
		int requests;
		int misses;
		int results;

		function new();
			foreach (x_tab[i]) begin
				x_tab[i] = '0;
				y_tab[i] = '0;
				cap_tab[i] = '0;
				cnt_tab[i] = '0;
			end
			sites_in_use = '0;
			mismatches = 0;
			loads = 0;
			requests = 0;
			misses = 0;
			results = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			if (mismatches < 100)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task note_input(logic func, bit [3:0] idx, bit [COORD_W-1:0] px,
			bit [COORD_W-1:0] py, bit [CAP_W-1:0] cap);
			alloc_result_t r;
			int span;
			int dx;
			int dy;
			int d;
			int best;
			int best_d;
			bit have;
			bit take;
			if (func == FUNC_LOAD) begin
				x_tab[idx] = px;
				y_tab[idx] = py;
				cap_tab[idx] = cap;
				cnt_tab[idx] = '0;
				loads++;
				return;
			end
			requests++;
			span = (sites_in_use > SITE_SLOTS) ? SITE_SLOTS : sites_in_use;
			have = 0;
			best = 0;
			best_d = 0;
			for (int i = 0; i < span; i++) begin
				if (cap_tab[i] == 0)
					continue;
				dx = (px > x_tab[i]) ? px - x_tab[i] : x_tab[i] - px;
				dy = (py > y_tab[i]) ? py - y_tab[i] : y_tab[i] - py;
				d = dx + dy;
				if (!have)
					take = 1;
				else if (d != best_d)
					take = d < best_d;
				else if (x_tab[i] != x_tab[best])
					take = x_tab[i] < x_tab[best];
				else
					take = y_tab[i] < y_tab[best];
				if (take) begin
					have = 1;
					best = i;
					best_d = d;
				end
			end
			r.found = have;
			r.site = '0;
			r.distance = '0;
			r.count = '0;
			if (have) begin
				cap_tab[best] = cap_tab[best] - 1'b1;
				cnt_tab[best] = cnt_tab[best] + 1'b1;
				r.site = best[3:0];
				r.distance = best_d[DIST_W-1:0];
				r.count = cnt_tab[best];
			end else begin
				misses++;
			end
			expected_q.push_back(r);
		endtask

		task check_result(bit found, bit [3:0] site, bit [DIST_W-1:0] distance,
			bit [CAP_W-1:0] count, bit [4:0] pad);
			alloc_result_t e;
			results++;
			if (expected_q.size() == 0) begin
				report("result transaction with no request outstanding");
				return;
			end
			e = expected_q.pop_front();
			if (found != e.found)
				report($sformatf("found %0d, expected %0d", found, e.found));
			if (site != e.site)
				report($sformatf("chosen_site %0d, expected %0d", site, e.site));
			if (distance != e.distance)
				report($sformatf("distance %0d, expected %0d", distance, e.distance));
			if (count != e.count)
				report($sformatf("site_count %0d, expected %0d", count, e.count));
			if (pad != '0)
				report($sformatf("padding bits 0x%0h, expected zero", pad));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [4:0]  cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	allocator_scoreboard sb = new();
	bit tx_busy;
	bit rx_busy;
	int hold_cycles;
	int cycle_count;

	nearest_capacity_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[18:4],
					m_axis_tdata[34:19], m_axis_tdata[39:35]);
				hold_cycles = rx_busy ? 0 : $urandom_range(0, 6);
				if (hold_cycles != 0)
					m_axis_tready <= 1'b0;
			end else if (!m_axis_tready) begin
				if (hold_cycles > 1)
					hold_cycles--;
				else
					m_axis_tready <= 1'b1;
			end
		end
	end

	task send_item(logic func, bit [3:0] idx, bit [COORD_W-1:0] px,
		bit [COORD_W-1:0] py, bit [CAP_W-1:0] cap);
		int gap;
		gap = tx_busy ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {cap, py, px, idx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(func, idx, px, py, cap);
	endtask

	task wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task write_sites(bit [4:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.sites_in_use = value;
	endtask

	function automatic bit [COORD_W-1:0] pick_coord(bit tight);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (tight)
			return COORD_W'($urandom_range(0, 7) * 4);
		return COORD_W'($urandom_range(0, 16383));
	endfunction

	function automatic bit [CAP_W-1:0] pick_capacity();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r == 2)
			return CAP_W'($urandom_range(0, 65535));
		return CAP_W'($urandom_range(1, 4));
	endfunction

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Run stopped after %0d cycles with work outstanding.", cycle_count);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		bit [4:0] plan [6];
		int sent;
		int phase;
		int phase_len;
		bit tight;
		plan = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_LOAD;
		m_axis_tready = 1'b1;
		hold_cycles = 0;
		cycle_count = 0;
		tx_busy = 0;
		rx_busy = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No site in use after reset, so the first request finds nothing.
		send_item(FUNC_REQUEST, 4'd0, 14'd500, 14'd500, 16'd0);
		send_item(FUNC_LOAD, 4'd0, 14'd0, 14'd0, 16'hFFFF);
		send_item(FUNC_LOAD, 4'd1, 14'h3FFF, 14'h3FFF, 16'd1);
		send_item(FUNC_LOAD, 4'd2, 14'd100, 14'd100, 16'd2);
		send_item(FUNC_LOAD, 4'd3, 14'd100, 14'd100, 16'd1);
		send_item(FUNC_LOAD, 4'd4, 14'd5000, 14'd9000, 16'd2);
		send_item(FUNC_LOAD, 4'd5, 14'd995, 14'd1005, 16'd1);
		send_item(FUNC_LOAD, 4'd6, 14'd995, 14'd995, 16'd1);
		send_item(FUNC_LOAD, 4'd7, 14'd1005, 14'd995, 16'd1);
		send_item(FUNC_LOAD, 4'd8, 14'd1000, 14'd1010, 16'd1);
		send_item(FUNC_LOAD, 4'd9, 14'h3FFF, 14'd0, 16'd0);
		send_item(FUNC_LOAD, 4'd10, 14'd0, 14'h3FFF, 16'd3);
		send_item(FUNC_LOAD, 4'd11, 14'h2AAA, 14'h1555, 16'hAAAA);
		send_item(FUNC_LOAD, 4'd12, 14'h1555, 14'h2AAA, 16'h5555);
		send_item(FUNC_LOAD, 4'd13, 14'd8191, 14'd8192, 16'd1);
		send_item(FUNC_LOAD, 4'd14, 14'd12000, 14'd3000, 16'd2);
		send_item(FUNC_LOAD, 4'd15, 14'd16000, 14'd16000, 16'd1);
		write_sites(5'd16);
		// Equal distances: same x with smaller y first, then smaller x.
		repeat (6) send_item(FUNC_REQUEST, 4'hF, 14'd1000, 14'd1000, 16'hFFFF);
		repeat (2) send_item(FUNC_REQUEST, 4'd0, 14'h3FFF, 14'h3FFF, 16'd0);
		send_item(FUNC_REQUEST, 4'd0, 14'd0, 14'd0, 16'd0);
		write_sites(5'd31);
		send_item(FUNC_REQUEST, 4'd9, 14'h3FFF, 14'd0, 16'd0);
		write_sites(5'd1);
		send_item(FUNC_REQUEST, 4'd0, 14'h3FFF, 14'h3FFF, 16'd0);

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			write_sites(phase < 6 ? plan[phase] : 5'($urandom_range(0, 31)));
			tx_busy = ($urandom_range(0, 3) == 0);
			rx_busy = ($urandom_range(0, 3) == 0);
			tight = 1'($urandom_range(0, 1));
			phase_len = $urandom_range(40, 90);
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < 35)
					send_item(FUNC_LOAD, 4'($urandom_range(0, 15)), pick_coord(tight),
						pick_coord(tight), pick_capacity());
				else
					send_item(FUNC_REQUEST, 4'($urandom_range(0, 15)), pick_coord(tight),
						pick_coord(tight), 16'($urandom_range(0, 65535)));
				sent++;
			end
			phase++;
		end

		tx_busy = 0;
		rx_busy = 0;
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d site loads and %0d requests over %0d random phases.",
			sb.loads, sb.requests, phase);
		$display("Checked %0d results, %0d of them with no free site; %0d mismatches.",
			sb.results, sb.misses, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/ncap_pkg.sv
sv/ncap_sequencer.sv
sv/ncap_site_mem.sv
sv/nearest_capacity_allocator.sv
sim/testbench.sv
